// ===== rtl/hav_pkg.sv =====
// Shared types, constants and the arctangent table for the haversine block.
`default_nettype none
package hav_pkg;

  localparam int LatW   = 28;
  localparam int LonW   = 29;
  localparam int MilesW = 22;
  // Angle word: 2^-28 degree units, wide enough for any encoded difference.
  localparam int AngW   = 40;
  // CORDIC vector word: Q30 with guard bits.
  localparam int VecW   = 34;

  localparam logic signed [AngW-1:0] Ang90  = 40'sd24159191040;
  localparam logic signed [AngW-1:0] Ang180 = 40'sd48318382080;
  localparam logic signed [AngW-1:0] Ang360 = 40'sd96636764160;
  localparam logic signed [VecW-1:0] InvGain = 34'sd652032874;
  localparam logic signed [VecW-1:0] OneQ30  = 34'sd1073741824;
  localparam logic [27:0] MilesMult = 28'd144798332;
  localparam logic [MilesW-1:0] MilesMax = 22'd3181600;

  localparam logic [0:0] RegLat = 1'b0;
  localparam logic [0:0] RegLon = 1'b1;

  typedef logic signed [AngW-1:0] ang_t;
  typedef logic signed [VecW-1:0] vec_t;

  // Front-to-back queue entry: reduced angles and negate flags.
  typedef struct packed {
    ang_t z_dlat;
    ang_t z_dlon;
    ang_t z_rlat;
    ang_t z_slat;
    logic [3:0] neg;
  } hav_job_t;

  // Arctangent of 2^-i in 2^-28 degree units.
  function automatic ang_t atan_lut(input logic [4:0] i);
    ang_t r;
    r = '0;
    case (i)
      5'd0: r = 40'sd12079595520;  5'd1: r = 40'sd7131001626;
      5'd2: r = 40'sd3767825416;   5'd3: r = 40'sd1912607013;
      5'd4: r = 40'sd960014949;    5'd5: r = 40'sd480475470;
      5'd6: r = 40'sd240296363;    5'd7: r = 40'sd120155514;
      5'd8: r = 40'sd60078674;     5'd9: r = 40'sd30039451;
      5'd10: r = 40'sd15019740;    5'd11: r = 40'sd7509872;
      5'd12: r = 40'sd3754936;     5'd13: r = 40'sd1877468;
      5'd14: r = 40'sd938734;      5'd15: r = 40'sd469367;
      5'd16: r = 40'sd234684;      5'd17: r = 40'sd117342;
      5'd18: r = 40'sd58671;       5'd19: r = 40'sd29335;
      5'd20: r = 40'sd14668;       5'd21: r = 40'sd7334;
      5'd22: r = 40'sd3667;        5'd23: r = 40'sd1833;
      5'd24: r = 40'sd917;         5'd25: r = 40'sd458;
      5'd26: r = 40'sd229;         5'd27: r = 40'sd115;
      5'd28: r = 40'sd57;          5'd29: r = 40'sd29;
      5'd30: r = 40'sd14;          5'd31: r = 40'sd7;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Wrap an angle into [-180,180), then fold beyond +-90 degrees.
  function automatic logic [AngW:0] reduce(input ang_t zin);
    ang_t z;
    logic n;
    z = zin;
    n = 1'b0;
    if (z >= Ang180) z = z - Ang360;
    if (z >= Ang180) z = z - Ang360;
    if (z < -Ang180) z = z + Ang360;
    if (z < -Ang180) z = z + Ang360;
    if (z > Ang90) begin
      z = z - Ang180;
      n = 1'b1;
    end else if (z < -Ang90) begin
      z = z + Ang180;
      n = 1'b1;
    end
    return {n, z};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/hav_if.sv =====
// Valid/ready stream interface used by both channels.
`default_nettype none
interface hav_if #(parameter int W = 1);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/hav_front.sv =====
// Front end: accepts sites, forms the four reduced angles and queues them.
`default_nettype none
module hav_front (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic signed [hav_pkg::LatW-1:0] ref_lat,
  input  wire logic signed [hav_pkg::LonW-1:0] ref_lon,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic signed [hav_pkg::LatW-1:0] in_lat,
  input  wire logic signed [hav_pkg::LonW-1:0] in_lon,
  output logic      q_valid,
  input  wire logic q_ready,
  output hav_pkg::hav_job_t q_job
);
  localparam int Depth = 4;
  localparam int Aw = $clog2(Depth);

  hav_pkg::hav_job_t mem_r [Depth];
  logic [Aw-1:0] wp_r, rp_r;
  logic [Aw:0] cnt_r, cnt_nxt;
  hav_pkg::hav_job_t job;
  logic [hav_pkg::AngW:0] r0, r1, r2, r3;
  logic push, pop;

  // Angle differences, latitudes and their reduction, one item per cycle while the queue has room.
  always_comb begin
    r0 = hav_pkg::reduce(hav_pkg::AngW'((41'(in_lat) - 41'(ref_lat)) <<< 7));
    r1 = hav_pkg::reduce(hav_pkg::AngW'((41'(in_lon) - 41'(ref_lon)) <<< 7));
    r2 = hav_pkg::reduce(hav_pkg::AngW'(41'(ref_lat) <<< 8));
    r3 = hav_pkg::reduce(hav_pkg::AngW'(41'(in_lat) <<< 8));
    job.z_dlat = r0[hav_pkg::AngW-1:0];
    job.z_dlon = r1[hav_pkg::AngW-1:0];
    job.z_rlat = r2[hav_pkg::AngW-1:0];
    job.z_slat = r3[hav_pkg::AngW-1:0];
    job.neg = {r3[hav_pkg::AngW], r2[hav_pkg::AngW], r1[hav_pkg::AngW], r0[hav_pkg::AngW]};
  end

  assign in_ready = (cnt_r != (Aw+1)'(Depth));
  assign q_valid  = (cnt_r != '0);
  assign push = in_valid && in_ready;
  assign pop  = q_valid && q_ready;
  assign q_job = mem_r[rp_r];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= job;
  end

  always_comb begin
    cnt_nxt = cnt_r + (Aw+1)'(push) - (Aw+1)'(pop);
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == (Aw+1)'(Depth) |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 |-> !pop) else $error("queue underflow");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (Aw+1)'(Depth)) else $error("queue count out of range");

endmodule
`default_nettype wire

// ===== rtl/hav_back.sv =====
// Back end: pipelined CORDIC rotation, products, roots, vectoring and scaling.
`default_nettype none
module hav_back #(
  parameter int Steps = 24
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire hav_pkg::hav_job_t in_job,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic [hav_pkg::MilesW-1:0] out_miles
);
  localparam int N = (Steps > 32) ? 32 : Steps;
  // Stage map: N rotate, 3 products, 1 clamp, 30 root, N vector, 2 scale.
  localparam int RootBits = 30;
  localparam int L = N + 3 + 1 + RootBits + N + 2;
  localparam int RW = 62;

  logic adv;
  logic [L-1:0] v_r;

  // Pipeline moves whenever the output register is free.
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[L-2:0], in_valid};
  end

  // Rotation: four sin/cos lanes side by side.
  hav_pkg::vec_t  rx_r [N+1][4];
  hav_pkg::vec_t  ry_r [N+1][4];
  hav_pkg::ang_t  rz_r [N+1][4];
  logic [3:0]     rn_r [N+1];

  always_comb begin
    rz_r[0][0] = in_job.z_dlat;
    rz_r[0][1] = in_job.z_dlon;
    rz_r[0][2] = in_job.z_rlat;
    rz_r[0][3] = in_job.z_slat;
    rn_r[0] = in_job.neg;
    for (int k = 0; k < 4; k++) begin
      rx_r[0][k] = hav_pkg::InvGain;
      ry_r[0][k] = '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (adv) begin
        rn_r[i+1] <= rn_r[i];
        for (int k = 0; k < 4; k++) begin
          if (!rz_r[i][k][hav_pkg::AngW-1]) begin
            rx_r[i+1][k] <= rx_r[i][k] - (ry_r[i][k] >>> i);
            ry_r[i+1][k] <= ry_r[i][k] + (rx_r[i][k] >>> i);
            rz_r[i+1][k] <= rz_r[i][k] - hav_pkg::atan_lut(5'(i));
          end else begin
            rx_r[i+1][k] <= rx_r[i][k] + (ry_r[i][k] >>> i);
            ry_r[i+1][k] <= ry_r[i][k] - (rx_r[i][k] >>> i);
            rz_r[i+1][k] <= rz_r[i][k] + hav_pkg::atan_lut(5'(i));
          end
        end
      end
    end
  end

  // Sines of the half-differences and cosines of the latitudes, sign applied.
  hav_pkg::vec_t s1, s2, c1, c2;
  always_comb begin
    s1 = rn_r[N][0] ? -ry_r[N][0] : ry_r[N][0];
    s2 = rn_r[N][1] ? -ry_r[N][1] : ry_r[N][1];
    c1 = rn_r[N][2] ? -rx_r[N][2] : rx_r[N][2];
    c2 = rn_r[N][3] ? -rx_r[N][3] : rx_r[N][3];
  end

  function automatic hav_pkg::vec_t rnd(input logic signed [67:0] p);
    logic signed [67:0] q;
    q = (p + 68'sd536870912) >>> 30;
    return q[hav_pkg::VecW-1:0];
  endfunction

  // Product stage one: s1^2, c1*c2, s2^2.
  hav_pkg::vec_t p_s11_r, p_t_r, p_s22_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      p_s11_r <= rnd(68'(s1) * 68'(s1));
      p_t_r   <= rnd(68'(c1) * 68'(c2));
      p_s22_r <= rnd(68'(s2) * 68'(s2));
    end
  end

  // Product stage two: t * s2^2.
  hav_pkg::vec_t q_s11_r, q_ts_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      q_s11_r <= p_s11_r;
      q_ts_r  <= rnd(68'(p_t_r) * 68'(p_s22_r));
    end
  end

  // Sum stage.
  logic signed [hav_pkg::VecW:0] a_r;
  always_ff @(posedge clk) begin
    if (adv) a_r <= 35'(q_s11_r) + 35'(q_ts_r);
  end

  // Clamp a to [0,1] and form the two radicands.
  logic [RW-1:0] ra_r [RootBits+1];
  logic [RW-1:0] rb_r [RootBits+1];
  logic [RW-1:0] qa_r [RootBits+1];
  logic [RW-1:0] qb_r [RootBits+1];
  logic [30:0] ac;
  always_comb begin
    if (a_r < 0) ac = '0;
    else if (a_r > 35'(hav_pkg::OneQ30)) ac = 31'd1073741824;
    else ac = a_r[30:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ra_r[0] <= RW'({ac, 30'd0});
      rb_r[0] <= RW'({31'd1073741824 - ac, 30'd0});
      qa_r[0] <= '0;
      qb_r[0] <= '0;
    end
  end

  // Digit-by-digit square root: one result bit per stage, MSB first. Each
  // stage tries the next power of four against the running remainder.
  for (genvar j = 0; j < RootBits; j++) begin : g_root
    localparam int Sh = 2 * (RootBits - j);
    logic [RW-1:0] ta, tb;
    assign ta = qa_r[j] + (RW'(1) << Sh);
    assign tb = qb_r[j] + (RW'(1) << Sh);
    always_ff @(posedge clk) begin
      if (adv) begin
        if (ra_r[j] >= ta) begin
          ra_r[j+1] <= ra_r[j] - ta;
          qa_r[j+1] <= (qa_r[j] >> 1) + (RW'(1) << Sh);
        end else begin
          ra_r[j+1] <= ra_r[j];
          qa_r[j+1] <= qa_r[j] >> 1;
        end
        if (rb_r[j] >= tb) begin
          rb_r[j+1] <= rb_r[j] - tb;
          qb_r[j+1] <= (qb_r[j] >> 1) + (RW'(1) << Sh);
        end else begin
          rb_r[j+1] <= rb_r[j];
          qb_r[j+1] <= qb_r[j] >> 1;
        end
      end
    end
  end

  // Final root bit (weight one) and start of vectoring.
  hav_pkg::vec_t vx_r [N+1];
  hav_pkg::vec_t vy_r [N+1];
  hav_pkg::ang_t vz_r [N+1];
  logic [RW-1:0] fa, fb;
  always_comb begin
    fa = (ra_r[RootBits] >= qa_r[RootBits] + RW'(1)) ? (qa_r[RootBits] >> 1) + RW'(1)
                                                     : qa_r[RootBits] >> 1;
    fb = (rb_r[RootBits] >= qb_r[RootBits] + RW'(1)) ? (qb_r[RootBits] >> 1) + RW'(1)
                                                     : qb_r[RootBits] >> 1;
    vx_r[0] = hav_pkg::VecW'(fb);
    vy_r[0] = hav_pkg::VecW'(fa);
    vz_r[0] = '0;
  end

  // Vectoring: rotate (sqrt(1-a), sqrt(a)) onto the x axis.
  for (genvar i = 0; i < N; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (adv) begin
        if (vy_r[i] > 0) begin
          vx_r[i+1] <= vx_r[i] + (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] - (vx_r[i] >>> i);
          vz_r[i+1] <= vz_r[i] + hav_pkg::atan_lut(5'(i));
        end else begin
          vx_r[i+1] <= vx_r[i] - (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] + (vx_r[i] >>> i);
          vz_r[i+1] <= vz_r[i] - hav_pkg::atan_lut(5'(i));
        end
      end
    end
  end

  // Scale: angle times the miles factor, then round and saturate.
  logic [35:0] zc;
  logic [63:0] prod_r;
  logic [23:0] m;
  always_comb begin
    zc = vz_r[N][hav_pkg::AngW-1] ? '0 : vz_r[N][35:0];
    m = prod_r[63:40] + 24'(prod_r[39]);
  end
  always_ff @(posedge clk) begin
    if (adv) prod_r <= 64'(zc) * 64'(hav_pkg::MilesMult);
  end

  always_ff @(posedge clk) begin
    if (adv) out_miles <= (m > 24'(hav_pkg::MilesMax)) ? hav_pkg::MilesMax
                                                       : m[hav_pkg::MilesW-1:0];
  end
  assign out_valid = v_r[L-1];

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v_r)) else $error("pipeline moved during stall");
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_miles <= hav_pkg::MilesMax) else $error("miles above max");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0]) else $error("item lost at entry");

endmodule
`default_nettype wire

// ===== rtl/haversine_distance.sv =====
// Top level: configuration registers, front-end queue and CORDIC back end.
// Accepts one site per cycle while the queue has room and returns one distance
// per site. The back end holds two CORDIC pipelines and a bit-per-stage square
// root; the four-entry queue between front and back lets either side stall
// independently.
`default_nettype none
module haversine_distance #(
  parameter int CORDIC_STEPS = 24
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [hav_pkg::LonW-1:0] cfg_data,
  hav_if.sink   in_ch,
  hav_if.source out_ch
);
  logic signed [hav_pkg::LatW-1:0] ref_lat_r;
  logic signed [hav_pkg::LonW-1:0] ref_lon_r;
  logic q_valid, q_ready;
  hav_pkg::hav_job_t q_job;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_lat_r <= '0;
      ref_lon_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        hav_pkg::RegLat: ref_lat_r <= cfg_data[hav_pkg::LatW-1:0];
        hav_pkg::RegLon: ref_lon_r <= cfg_data;
        default: ;
      endcase
    end
  end

  hav_front u_front (
    .clk, .rst_n,
    .ref_lat(ref_lat_r), .ref_lon(ref_lon_r),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_lat(in_ch.data[hav_pkg::LatW-1:0]),
    .in_lon(in_ch.data[hav_pkg::LatW+hav_pkg::LonW-1:hav_pkg::LatW]),
    .q_valid, .q_ready, .q_job
  );

  hav_back #(.Steps(CORDIC_STEPS)) u_back (
    .clk, .rst_n,
    .in_valid(q_valid), .in_ready(q_ready), .in_job(q_job),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_miles(out_ch.data)
  );

endmodule
`default_nettype wire

// ===== tb/haversine_distance_test.sv =====
// Self-checking testbench for the haversine distance block with a built-in distance predictor.
`default_nettype none
module haversine_distance_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Steps = 24;
  localparam int UseSteps = (Steps > 32) ? 32 : Steps;
  localparam int InW = hav_pkg::LatW + hav_pkg::LonW;
  localparam logic signed [hav_pkg::LatW-1:0] LatTop = 28'sd94371840;
  localparam logic signed [hav_pkg::LonW-1:0] LonTop = 29'sd188743680;
  localparam longint Deg90 = 64'sd24159191040;
  localparam longint Deg180 = 64'sd48318382080;
  localparam longint Deg360 = 64'sd96636764160;
  localparam longint Q30One = 64'sd1073741824;
  localparam longint Q30Half = 64'sd536870912;
  localparam longint unsigned DistMult = 64'd144798332;
  localparam longint unsigned DistMax = 64'd3181600;
  localparam int CycleLimit = 600000;
  localparam int DrainCycles = 2 * Steps + 60;

  // Arctangent of 2^-i in 2^-28 degree units.
  localparam longint ArcTab [32] = '{
    64'sd12079595520, 64'sd7131001626, 64'sd3767825416, 64'sd1912607013,
    64'sd960014949, 64'sd480475470, 64'sd240296363, 64'sd120155514,
    64'sd60078674, 64'sd30039451, 64'sd15019740, 64'sd7509872,
    64'sd3754936, 64'sd1877468, 64'sd938734, 64'sd469367,
    64'sd234684, 64'sd117342, 64'sd58671, 64'sd29335,
    64'sd14668, 64'sd7334, 64'sd3667, 64'sd1833,
    64'sd917, 64'sd458, 64'sd229, 64'sd115,
    64'sd57, 64'sd29, 64'sd14, 64'sd7
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [hav_pkg::LonW-1:0] cfg_data;

  hav_if #(.W(InW)) in_ch ();
  hav_if #(.W(hav_pkg::MilesW)) out_ch ();

  haversine_distance dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  // Predictor copy of the reference point registers.
  logic signed [hav_pkg::LatW-1:0] home_lat;
  logic signed [hav_pkg::LonW-1:0] home_lon;

  logic [hav_pkg::MilesW-1:0] expected_miles [$];
  int failures;
  int cycles;
  int results_seen;
  bit idle_on;
  bit hold_go;
  int hold_cnt;
  int stall_cnt;

  // The clock runs with a 20 ns period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Sine and cosine in Q30 of an angle in 2^-28 degree units.
  function automatic void sin_cos(input longint ang, output longint s, output longint c);
    longint z, x, y, xs, ys;
    bit flip;
    z = ang;
    flip = 1'b0;
    x = 64'sd652032874;
    y = 0;
    if (z >= Deg180) z = z - Deg360;
    if (z >= Deg180) z = z - Deg360;
    if (z < -Deg180) z = z + Deg360;
    if (z < -Deg180) z = z + Deg360;
    if (z > Deg90) begin
      z = z - Deg180;
      flip = 1'b1;
    end else if (z < -Deg90) begin
      z = z + Deg180;
      flip = 1'b1;
    end
    for (int i = 0; i < UseSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - ArcTab[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + ArcTab[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  // Angle of the vector (y, x) by vectoring rotation.
  function automatic longint vector_angle(input longint yin, input longint xin);
    longint x, y, z, xs, ys;
    x = xin;
    y = yin;
    z = 0;
    for (int i = 0; i < UseSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ArcTab[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ArcTab[i];
      end
    end
    return z;
  endfunction

  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r, b, rem;
    r = 0;
    rem = v;
    b = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint q30_round(input longint p);
    return (p + Q30Half) >>> 30;
  endfunction

  // Distance in 1/256 mile from the reference point to one site.
  function automatic logic [hav_pkg::MilesW-1:0] site_miles(
      input logic signed [hav_pkg::LatW-1:0] slat,
      input logic signed [hav_pkg::LonW-1:0] slon);
    longint rl, rg, sl, sg, s1, c1, s2, c2, t, unused, a, z;
    longint unsigned ra, rb, m;
    rl = home_lat;
    rg = home_lon;
    sl = slat;
    sg = slon;
    sin_cos((sl - rl) * 128, s1, unused);
    sin_cos((sg - rg) * 128, s2, unused);
    sin_cos(rl * 256, unused, c1);
    sin_cos(sl * 256, unused, c2);
    t = q30_round(c1 * c2);
    a = q30_round(s1 * s1) + q30_round(t * q30_round(s2 * s2));
    if (a < 0) a = 0;
    if (a > Q30One) a = Q30One;
    ra = floor_root(longint'(a) << 30);
    rb = floor_root(longint'(Q30One - a) << 30);
    z = vector_angle(longint'(ra), longint'(rb));
    if (z < 0) z = 0;
    m = (longint'(z) * DistMult + (64'd1 << 39)) >> 40;
    if (m > DistMax) m = DistMax;
    return m[hav_pkg::MilesW-1:0];
  endfunction

  // Receiver: random stalls, plus a long hold-off when a test asks for one.
  always @(negedge clk) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt = stall_cnt - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_cnt = $urandom_range(1, 13) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Compare each returned distance with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_miles.size() == 0) begin
        failures++;
        $display("%0t: unexpected distance, expected none, actual %0d", $time, out_ch.data);
      end else begin
        if (out_ch.data !== expected_miles[0]) begin
          failures++;
          $display("%0t: miles mismatch, expected %0d, actual %0d", $time,
                   expected_miles[0], out_ch.data);
        end
        void'(expected_miles.pop_front());
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d distances outstanding", cycles,
               expected_miles.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Send one site request; returns at a falling edge with valid still high.
  task automatic send_site(input logic signed [hav_pkg::LatW-1:0] lat,
                           input logic signed [hav_pkg::LonW-1:0] lon);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= {lon, lat};
    do @(posedge clk); while (!in_ch.ready);
    expected_miles.push_back(site_miles(lat, lon));
    @(negedge clk);
  endtask

  // Lower valid and wait for every outstanding distance, plus a wait longer than the pipeline depth.
  task automatic drain;
    in_ch.valid <= 1'b0;
    wait (expected_miles.size() == 0);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reference(input logic signed [hav_pkg::LatW-1:0] lat,
                                 input logic signed [hav_pkg::LonW-1:0] lon);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= hav_pkg::RegLat;
    cfg_data <= hav_pkg::LonW'(lat);
    home_lat = lat;
    @(negedge clk);
    cfg_index <= hav_pkg::RegLon;
    cfg_data <= lon;
    home_lon = lon;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic signed [hav_pkg::LatW-1:0] pick_lat(input bit any);
    if (any) return hav_pkg::LatW'($urandom);
    return hav_pkg::LatW'(longint'($urandom_range(0, 2 * LatTop)) - LatTop);
  endfunction

  function automatic logic signed [hav_pkg::LonW-1:0] pick_lon(input bit any);
    if (any) return hav_pkg::LonW'($urandom);
    return hav_pkg::LonW'(longint'($urandom_range(0, 2 * LonTop)) - LonTop);
  endfunction

  // Corners of the coordinate ranges, identical and antipodal points, and
  // latitudes past the poles that give a negative cosine.
  task automatic test_corners;
    send_site('0, '0);
    send_site(LatTop, '0);
    send_site(-LatTop, '0);
    send_site('0, LonTop);
    send_site('0, -LonTop);
    send_site(LatTop, LonTop);
    send_site(-LatTop, -LonTop);
    send_site({1'b0, {(hav_pkg::LatW-1){1'b1}}}, {1'b0, {(hav_pkg::LonW-1){1'b1}}});
    send_site({1'b1, {(hav_pkg::LatW-1){1'b0}}}, {1'b1, {(hav_pkg::LonW-1){1'b0}}});
    send_site('1, '1);
    send_site(hav_pkg::LatW'(1), hav_pkg::LonW'(1));
    send_site(hav_pkg::LatW'(longint'(LatTop) + 20000000), hav_pkg::LonW'(5000000));
    send_site(hav_pkg::LatW'(-longint'(LatTop) - 30000000), hav_pkg::LonW'(-120000000));
    send_site('0, hav_pkg::LonW'(longint'(LonTop) - 1));
    send_site(hav_pkg::LatW'(1000), LonTop);
    send_site(hav_pkg::LatW'(LatTop / 2), hav_pkg::LonW'(LonTop / 2));
    write_reference(LatTop, LonTop);
    send_site(-LatTop, -LonTop);
    send_site(LatTop, LonTop);
    send_site(-LatTop, '0);
    write_reference(-LatTop, -LonTop);
    send_site(LatTop, LonTop);
    send_site('0, '0);
    write_reference({1'b1, {(hav_pkg::LatW-1){1'b0}}}, {1'b1, {(hav_pkg::LonW-1){1'b0}}});
    send_site({1'b0, {(hav_pkg::LatW-1){1'b1}}}, {1'b0, {(hav_pkg::LonW-1){1'b1}}});
    send_site('0, '0);
  endtask

  // Random sites, mostly in range, some with arbitrary bit patterns.
  task automatic test_random_sites(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) send_site(pick_lat(1), pick_lon(1));
      else send_site(pick_lat(0), pick_lon(0));
    end
  endtask

  // Near-identical sites exercise distances close to zero.
  task automatic test_near_points(input int count);
    for (int i = 0; i < count; i++)
      send_site(hav_pkg::LatW'(longint'(home_lat) + $urandom_range(0, 4000) - 2000),
                hav_pkg::LonW'(longint'(home_lon) + $urandom_range(0, 4000) - 2000));
  endtask

  // Receiver holds off for a long time while sites keep coming.
  task automatic test_backpressure;
    idle_on = 1'b0;
    hold_go = 1'b1;
    test_random_sites(150);
    drain();
    idle_on = 1'b1;
  endtask

  initial begin
    failures = 0;
    cycles = 0;
    results_seen = 0;
    idle_on = 1'b1;
    hold_go = 1'b0;
    hold_cnt = 0;
    stall_cnt = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = hav_pkg::RegLat;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    home_lat = '0;
    home_lon = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_corners();
    write_reference('0, '0);
    test_random_sites(200);
    test_backpressure();
    write_reference(pick_lat(0), pick_lon(0));
    test_near_points(60);
    test_random_sites(200);
    write_reference(pick_lat(1), pick_lon(1));
    test_random_sites(180);
    write_reference(LatTop, -LonTop);
    test_random_sites(100);
    // Final stretch runs with no idling on either side.
    write_reference(pick_lat(0), pick_lon(0));
    idle_on = 1'b0;
    test_random_sites(150);
    drain();

    $display("Checked %0d distances over several reference points, including range corners,",
             results_seen);
    $display("near-zero and antipodal distances, random stalls and a long output hold-off.");
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", failures);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
